// ===== design/slx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_pkg: shared types and tables for the source lexer
// Result records, lexer states, word tables and character classes.
// ----------------------------------------------------------------------------
package slx_pkg;

  localparam int IntegerBitsDef  = 64;
  localparam int MaxHexDigitsDef = 7;
  localparam int QueueDepth      = 4;
  localparam int NumWords        = 14;

  localparam logic [4:0] KindString   = 5'd0;
  localparam logic [4:0] KindOperator = 5'd1;
  localparam logic [4:0] KindOpenPar  = 5'd2;
  localparam logic [4:0] KindClosePar = 5'd3;
  localparam logic [4:0] KindOpenBr   = 5'd4;
  localparam logic [4:0] KindCloseBr  = 5'd5;
  localparam logic [4:0] KindColon    = 5'd6;
  localparam logic [4:0] KindComma    = 5'd7;
  localparam logic [4:0] KindAssign   = 5'd8;
  localparam logic [4:0] KindCompare  = 5'd9;
  localparam logic [4:0] KindBang     = 5'd10;
  localparam logic [4:0] KindKeyword  = 5'd11;
  localparam logic [4:0] KindType     = 5'd12;
  localparam logic [4:0] KindIdent    = 5'd13;
  localparam logic [4:0] KindInteger  = 5'd14;
  localparam logic [4:0] KindDouble   = 5'd15;
  localparam logic [4:0] KindArrow    = 5'd16;
  localparam logic [4:0] KindNewline  = 5'd17;
  localparam logic [4:0] KindUnder    = 5'd18;

  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrUnknown  = 3'd1;
  localparam logic [2:0] ErrType     = 3'd2;
  localparam logic [2:0] ErrOverflow = 3'd3;
  localparam logic [2:0] ErrEscape   = 3'd4;

  localparam logic [2:0] EscIdle  = 3'd0;
  localparam logic [2:0] EscSlash = 3'd1;
  localparam logic [2:0] EscU     = 3'd2;
  localparam logic [2:0] EscHex   = 3'd3;

  typedef enum logic [4:0] {
    S_START, S_STR_OPEN, S_STR_BODY, S_STR_EMPTY, S_ML_OPEN, S_ML_BODY, S_ML_NL,
    S_ML_Q1, S_ML_Q2, S_SLASH, S_LINE_CMT, S_BLK, S_BLK_STAR, S_QMARK, S_ASSIGN,
    S_CMP, S_BANG, S_IDENT, S_UNDER, S_IDTYPE, S_INT, S_DBL_DOT, S_DBL, S_EXP,
    S_EXP_SIGN, S_EXP_DIG, S_DASH, S_DONE
  } lex_state_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] content_byte;
    logic       token_end;
    logic [4:0] token_kind;
    logic [2:0] error_code;
    logic       input_done;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r1;
    res_t       r0;
  } rbuf_t;

  localparam logic [NumWords-1:0][63:0] WordTab = {
    64'("String?"), 64'("String"), 64'("Int?"), 64'("Int"), 64'("Double?"),
    64'("Double"), 64'("while"), 64'("var"), 64'("return"), 64'("nil"),
    64'("let"), 64'("if"), 64'("func"), 64'("else")
  };
  localparam logic [NumWords-1:0][3:0] WordLen = {
    4'd7, 4'd6, 4'd4, 4'd3, 4'd7, 4'd6, 4'd5, 4'd3, 4'd6, 4'd3, 4'd3, 4'd2,
    4'd4, 4'd4
  };

  function automatic res_t mk_res(logic h, logic [7:0] b, logic te, logic [4:0] k,
                                  logic [2:0] e, logic d);
    res_t r;
    r.has_byte     = h;
    r.content_byte = b;
    r.token_end    = te;
    r.token_kind   = k;
    r.error_code   = e;
    r.input_done   = d;
    return r;
  endfunction

  function automatic rbuf_t push(rbuf_t b, res_t x);
    rbuf_t o;
    o = b;
    if (b.cnt == 2'd0) begin
      o.r0  = x;
      o.cnt = 2'd1;
    end else if (b.cnt == 2'd1) begin
      o.r1  = x;
      o.cnt = 2'd2;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_digit(c) || is_alpha(c) || c == "_";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] hex_of(logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (is_digit(c)) h = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") h = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") h = {1'b1, 4'(c - "A" + 8'd10)};
    return h;
  endfunction

  function automatic logic [NumWords-1:0] match_mask(logic [NumWords-1:0] m,
                                                     logic [3:0] p, logic [7:0] c);
    logic [NumWords-1:0] o;
    logic [3:0]          sh;
    o = m;
    for (int i = 0; i < NumWords; i++) begin
      sh = WordLen[i] - 4'd1 - p;
      if (!(p < WordLen[i] && WordTab[i][{sh[2:0], 3'b000} +: 8] == c)) o[i] = 1'b0;
    end
    return o;
  endfunction

  function automatic logic [NumWords-1:0] complete_words(logic [NumWords-1:0] m,
                                                         logic [3:0] p);
    logic [NumWords-1:0] o;
    for (int i = 0; i < NumWords; i++) o[i] = m[i] && WordLen[i] == p;
    return o;
  endfunction

endpackage

// ===== design/slx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_in_if / slx_out_if: lexer channels
// Valid/ready channels for source bytes and lexer results.
// ----------------------------------------------------------------------------
interface slx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;
  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink (input valid, char_byte, end_of_input, output ready);
endinterface

interface slx_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] content_byte;
  logic       token_end;
  logic [4:0] token_kind;
  logic [2:0] error_code;
  logic       input_done;
  logic       last_of_run;
  modport source (output valid, has_byte, content_byte, token_end, token_kind,
                  error_code, input_done, last_of_run, input ready);
  modport sink (input valid, has_byte, content_byte, token_end, token_kind,
                error_code, input_done, last_of_run, output ready);
endinterface

// ===== design/slx_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_front: lexer state machine
// Classifies each source byte and builds the result records it causes.
// ----------------------------------------------------------------------------
module slx_front
  import slx_pkg::*;
#(
  parameter int IntegerBits  = IntegerBitsDef,
  parameter int MaxHexDigits = MaxHexDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_input_i,
  output rbuf_t      res_o
);

  localparam logic [IntegerBits+3:0] MaxVal = (IntegerBits+4)'({(IntegerBits-1){1'b1}});

  lex_state_e            st_q, st_d;
  logic [4:0]            kind_q, kind_d;
  logic [NumWords-1:0]   mask_q, mask_d;
  logic [3:0]            pos_q, pos_d;
  logic [IntegerBits-1:0] ival_q, ival_d;
  logic                  ovf_q, ovf_d;
  logic [2:0]            esc_q, esc_d;
  logic [8:0]            hex_q, hex_d;
  logic [2:0]            hcnt_q, hcnt_d;
  logic                  hnl_q, hnl_d;
  logic [2:0]            err_q, err_d;

  always_comb begin
    rbuf_t               rb;
    logic [7:0]          c;
    logic                eof, fc, endtok, dostart, mw, ad, emit;
    logic [4:0]          hx;
    logic [12:0]         hsum;
    logic [IntegerBits+3:0] isum;
    logic [NumWords-1:0] w;
    rb      = '0;
    eof     = end_of_input_i;
    c       = eof ? 8'd0 : char_byte_i;
    fc      = 1'b0;
    endtok  = 1'b0;
    dostart = 1'b0;
    mw      = 1'b0;
    ad      = 1'b0;
    emit    = 1'b0;
    hx      = 5'd0;
    hsum    = 13'd0;
    isum    = '0;
    w       = '0;
    st_d    = st_q;
    kind_d  = kind_q;
    mask_d  = mask_q;
    pos_d   = pos_q;
    ival_d  = ival_q;
    ovf_d   = ovf_q;
    esc_d   = esc_q;
    hex_d   = hex_q;
    hcnt_d  = hcnt_q;
    hnl_d   = hnl_q;
    err_d   = err_q;
    if (err_q != ErrNone) begin
      rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, err_q, 1'b0));
    end else begin
      case (st_q)
        S_DONE, S_IDTYPE: endtok = 1'b1;
        S_STR_OPEN, S_STR_BODY: begin
          if (eof) begin
            err_d = ErrUnknown;
          end else if (esc_q == EscSlash) begin
            fc = 1'b1; st_d = S_STR_BODY;
          end else if (c <= 8'd31) begin
            err_d = ErrUnknown;
          end else if (esc_q >= EscU) begin
            fc = 1'b1;
          end else if (c == "\"") begin
            if (st_q == S_STR_OPEN) st_d = S_STR_EMPTY;
            else begin
              st_d = S_DONE; kind_d = KindString;
            end
          end else begin
            fc = 1'b1; st_d = S_STR_BODY;
          end
        end
        S_STR_EMPTY: begin
          if (!eof && c == "\"") st_d = S_ML_OPEN;
          else endtok = 1'b1;
        end
        S_ML_OPEN: begin
          if (!eof && c == 8'd10) st_d = S_ML_BODY;
          else err_d = ErrUnknown;
        end
        S_ML_BODY: begin
          if (eof) err_d = ErrUnknown;
          else if (c == 8'd10) begin
            if (esc_q != EscIdle) err_d = ErrEscape;
            else begin
              hnl_d = 1'b1; st_d = S_ML_NL;
            end
          end else if (c <= 8'd31) err_d = ErrUnknown;
          else fc = 1'b1;
        end
        S_ML_NL: begin
          if (eof) err_d = ErrUnknown;
          else if (c == "\"") begin
            hnl_d = 1'b0; st_d = S_ML_Q1;
          end else if (c == 8'd10) begin
            rb = push(rb, mk_res(1'b1, 8'd10, 1'b0, 5'd0, ErrNone, 1'b0));
          end else begin
            rb = push(rb, mk_res(1'b1, 8'd10, 1'b0, 5'd0, ErrNone, 1'b0));
            hnl_d = 1'b0; st_d = S_ML_BODY; fc = 1'b1;
          end
        end
        S_ML_Q1, S_ML_Q2: begin
          if (!eof && c == "\"") begin
            if (st_q == S_ML_Q1) st_d = S_ML_Q2;
            else begin
              st_d = S_DONE; kind_d = KindString;
            end
          end else err_d = ErrUnknown;
        end
        S_SLASH: begin
          if (!eof && c == "/") st_d = S_LINE_CMT;
          else if (!eof && c == "*") st_d = S_BLK;
          else endtok = 1'b1;
        end
        S_LINE_CMT: endtok = eof || c == 8'd10;
        S_BLK: begin
          if (eof) err_d = ErrUnknown;
          else if (c == "*") st_d = S_BLK_STAR;
        end
        S_BLK_STAR: begin
          if (eof) err_d = ErrUnknown;
          else if (c == "/") begin
            st_d = S_START; mask_d = '1; pos_d = '0; ival_d = '0; ovf_d = 1'b0;
            esc_d = EscIdle; hex_d = '0; hcnt_d = '0; hnl_d = 1'b0;
          end else st_d = S_BLK;
        end
        S_QMARK: begin
          if (!eof && c == "?") begin
            emit = 1'b1; st_d = S_DONE; kind_d = KindOperator;
          end else err_d = ErrUnknown;
        end
        S_ASSIGN, S_CMP, S_BANG: begin
          if (!eof && c == "=") begin
            emit = 1'b1; st_d = S_DONE; kind_d = KindCompare;
          end else endtok = 1'b1;
        end
        S_IDENT, S_UNDER: begin
          if (!eof && is_word(c)) begin
            mw = 1'b1; emit = 1'b1; st_d = S_IDENT;
          end else if (st_q == S_IDENT && !eof && c == "?") begin
            mw = 1'b1; emit = 1'b1; st_d = S_IDTYPE;
          end else endtok = 1'b1;
        end
        S_INT: begin
          if (eof) endtok = 1'b1;
          else if (is_digit(c)) begin
            ad = 1'b1; emit = 1'b1;
          end else if (c == ".") begin
            emit = 1'b1; st_d = S_DBL_DOT;
          end else if (c == "e" || c == "E") begin
            emit = 1'b1; st_d = S_EXP;
          end else endtok = 1'b1;
        end
        S_DBL_DOT, S_EXP_SIGN: begin
          if (!eof && is_digit(c)) begin
            emit = 1'b1; st_d = (st_q == S_DBL_DOT) ? S_DBL : S_EXP_DIG;
          end else err_d = ErrUnknown;
        end
        S_DBL: begin
          if (eof) endtok = 1'b1;
          else if (is_digit(c)) emit = 1'b1;
          else if (c == "e" || c == "E") begin
            emit = 1'b1; st_d = S_EXP;
          end else endtok = 1'b1;
        end
        S_EXP: begin
          if (!eof && (c == "+" || c == "-")) begin
            emit = 1'b1; st_d = S_EXP_SIGN;
          end else if (!eof && is_digit(c)) begin
            emit = 1'b1; st_d = S_EXP_DIG;
          end else err_d = ErrUnknown;
        end
        S_EXP_DIG: begin
          if (!eof && is_digit(c)) emit = 1'b1;
          else endtok = 1'b1;
        end
        S_DASH: begin
          if (!eof && c == ">") begin
            emit = 1'b1; st_d = S_DONE; kind_d = KindArrow;
          end else endtok = 1'b1;
        end
        default: dostart = 1'b1;
      endcase

      if (err_d != ErrNone) begin
        rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, err_d, 1'b0));
      end
      if (emit) rb = push(rb, mk_res(1'b1, c, 1'b0, 5'd0, ErrNone, 1'b0));

      // string content with escape decoding
      if (fc) begin
        hx = hex_of(c);
        hsum = {hex_q, 4'd0} + 13'(hx[3:0]);
        case (esc_q)
          EscIdle: begin
            if (c == "\\") esc_d = EscSlash;
            else rb = push(rb, mk_res(1'b1, c, 1'b0, 5'd0, ErrNone, 1'b0));
          end
          EscSlash: begin
            esc_d = EscIdle;
            if (c == "n") rb = push(rb, mk_res(1'b1, 8'd10, 1'b0, 5'd0, ErrNone, 1'b0));
            else if (c == "t") rb = push(rb, mk_res(1'b1, 8'd9, 1'b0, 5'd0, ErrNone, 1'b0));
            else if (c == "\"" || c == "\\")
              rb = push(rb, mk_res(1'b1, c, 1'b0, 5'd0, ErrNone, 1'b0));
            else if (c == "u") esc_d = EscU;
            else err_d = ErrEscape;
          end
          EscU: begin
            if (c == "{") begin
              esc_d = EscHex; hex_d = '0; hcnt_d = '0;
            end else err_d = ErrEscape;
          end
          EscHex: begin
            if (hx[4]) begin
              if (hcnt_q >= 3'(MaxHexDigits)) err_d = ErrEscape;
              else begin
                hex_d  = (hsum > 13'd256) ? 9'd256 : hsum[8:0];
                hcnt_d = hcnt_q + 3'd1;
              end
            end else if (c == "}") begin
              if (hcnt_q == 3'd0 || hex_q > 9'd255) err_d = ErrEscape;
              else begin
                rb = push(rb, mk_res(1'b1, hex_q[7:0], 1'b0, 5'd0, ErrNone, 1'b0));
                esc_d = EscIdle;
              end
            end else err_d = ErrEscape;
          end
          default: err_d = ErrEscape;
        endcase
        if (err_d != ErrNone) begin
          rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, err_d, 1'b0));
        end
      end

      if (endtok) begin
        w = complete_words(mask_q, pos_q);
        case (st_q)
          S_DONE: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, kind_q, ErrNone, 1'b0));
          S_STR_EMPTY: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindString, ErrNone, 1'b0));
          S_SLASH: rb = push(rb, mk_res(1'b1, "/", 1'b1, KindOperator, ErrNone, 1'b0));
          S_ASSIGN: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindAssign, ErrNone, 1'b0));
          S_CMP: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindCompare, ErrNone, 1'b0));
          S_BANG: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindBang, ErrNone, 1'b0));
          S_DASH: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindOperator, ErrNone, 1'b0));
          S_UNDER: rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindUnder, ErrNone, 1'b0));
          S_IDENT: begin
            rb = push(rb, mk_res(1'b0, 8'd0, 1'b1,
                                 (w[7:0] != '0) ? KindKeyword :
                                 ((w[13:8] != '0) ? KindType : KindIdent),
                                 ErrNone, 1'b0));
          end
          S_IDTYPE: begin
            if (w[13:8] != '0)
              rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindType, ErrNone, 1'b0));
            else begin
              err_d = ErrType;
              rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, ErrType, 1'b0));
            end
          end
          S_INT: begin
            if (ovf_q) begin
              err_d = ErrOverflow;
              rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, ErrOverflow, 1'b0));
            end else rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindInteger, ErrNone, 1'b0));
          end
          S_DBL, S_EXP_DIG:
            rb = push(rb, mk_res(1'b0, 8'd0, 1'b1, KindDouble, ErrNone, 1'b0));
          default: ;
        endcase
        st_d = S_START; mask_d = '1; pos_d = '0; ival_d = '0; ovf_d = 1'b0;
        esc_d = EscIdle; hex_d = '0; hcnt_d = '0; hnl_d = 1'b0;
        dostart = (err_d == ErrNone);
      end

      if (dostart) begin
        st_d = S_START;
        if (eof) begin
          mask_d = '1; pos_d = '0; ival_d = '0; ovf_d = 1'b0;
          esc_d = EscIdle; hex_d = '0; hcnt_d = '0; hnl_d = 1'b0;
          rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, ErrNone, 1'b1));
        end else begin
          emit = 1'b1;
          case (c)
            "\"": begin emit = 1'b0; st_d = S_STR_OPEN; end
            "/": begin emit = 1'b0; st_d = S_SLASH; end
            8'd10: begin emit = 1'b0; st_d = S_DONE; kind_d = KindNewline; end
            "?": st_d = S_QMARK;
            "(": begin st_d = S_DONE; kind_d = KindOpenPar; end
            ")": begin st_d = S_DONE; kind_d = KindClosePar; end
            "{": begin st_d = S_DONE; kind_d = KindOpenBr; end
            "}": begin st_d = S_DONE; kind_d = KindCloseBr; end
            ":": begin st_d = S_DONE; kind_d = KindColon; end
            ",": begin st_d = S_DONE; kind_d = KindComma; end
            "*", "+": begin st_d = S_DONE; kind_d = KindOperator; end
            "=": st_d = S_ASSIGN;
            "<", ">": st_d = S_CMP;
            "!": st_d = S_BANG;
            "-": st_d = S_DASH;
            "_": begin mw = 1'b1; st_d = S_UNDER; end
            default: begin
              if (is_alpha(c)) begin
                mw = 1'b1; st_d = S_IDENT;
              end else if (is_digit(c)) begin
                ad = 1'b1; st_d = S_INT;
              end else if (is_space(c)) begin
                emit = 1'b0;
              end else begin
                emit = 1'b0; err_d = ErrUnknown;
                rb = push(rb, mk_res(1'b0, 8'd0, 1'b0, 5'd0, ErrUnknown, 1'b0));
              end
            end
          endcase
          if (emit) rb = push(rb, mk_res(1'b1, c, 1'b0, 5'd0, ErrNone, 1'b0));
        end
      end

      if (mw) begin
        mask_d = match_mask(mask_d, pos_d, c);
        if (pos_d != 4'd15) pos_d = pos_d + 4'd1;
      end
      if (ad && !ovf_d) begin
        isum = {1'b0, ival_d, 3'b000} + {3'b000, ival_d, 1'b0} + (IntegerBits+4)'(c - "0");
        if (isum > MaxVal) ovf_d = 1'b1;
        else ival_d = isum[IntegerBits-1:0];
      end
    end
    res_o = rb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_START;
      kind_q <= '0;
      mask_q <= '1;
      pos_q  <= '0;
      ival_q <= '0;
      ovf_q  <= 1'b0;
      esc_q  <= EscIdle;
      hex_q  <= '0;
      hcnt_q <= '0;
      hnl_q  <= 1'b0;
      err_q  <= ErrNone;
    end else if (take_i) begin
      st_q   <= st_d;
      kind_q <= kind_d;
      mask_q <= mask_d;
      pos_q  <= pos_d;
      ival_q <= ival_d;
      ovf_q  <= ovf_d;
      esc_q  <= esc_d;
      hex_q  <= hex_d;
      hcnt_q <= hcnt_d;
      hnl_q  <= hnl_d;
      err_q  <= err_d;
    end
  end

endmodule

// ===== design/slx_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_queue: result record queue
// Short queue of per-byte result groups between lexer and output stage.
// ----------------------------------------------------------------------------
module slx_queue
  import slx_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  rbuf_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output rbuf_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  rbuf_t                mem_q [Depth];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]        cnt_q, cnt_d;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      cnt_d = cnt_d + (PtrW+1)'(1);
    end
    if (pop_i) begin
      rd_d  = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      cnt_d = cnt_d - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== design/slx_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_back: result sender
// Sends the one or two results of each queued group, marking the last.
// ----------------------------------------------------------------------------
module slx_back
  import slx_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  empty_i,
  input  rbuf_t head_i,
  output logic  pop_o,
  slx_out_if.source out_o
);

  logic sel_q, sel_d;
  logic last;
  res_t cur;

  assign cur   = sel_q ? head_i.r1 : head_i.r0;
  assign last  = sel_q || head_i.cnt == 2'd1;
  assign pop_o = out_o.valid && out_o.ready && last;

  assign out_o.valid        = !empty_i;
  assign out_o.has_byte     = cur.has_byte;
  assign out_o.content_byte = cur.content_byte;
  assign out_o.token_end    = cur.token_end;
  assign out_o.token_kind   = cur.token_kind;
  assign out_o.error_code   = cur.error_code;
  assign out_o.input_done   = cur.input_done;
  assign out_o.last_of_run  = last;

  always_comb begin
    sel_d = sel_q;
    if (out_o.valid && out_o.ready) sel_d = !last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sel_q <= 1'b0;
    else sel_q <= sel_d;
  end

endmodule

// ===== design/source_lexer_dfa.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_lexer_dfa: streaming source lexer
// Lexer state machine feeding a result queue and an output sender.
//
//   channel  dir  payload
//   in_i     in   char_byte, end_of_input
//   out_o    out  has_byte, content_byte, token_end, token_kind, error_code,
//                 input_done, last_of_run
//
// One byte per cycle is taken while the result queue has room.
// A byte causing two results is sent as two output transfers, the second marked last_of_run.
// Reset returns the lexer to its start state and empties the queue.
// Output stalls fill the queue, then hold off input.
// ----------------------------------------------------------------------------
module source_lexer_dfa
  import slx_pkg::*;
#(
  parameter int IntegerBits  = IntegerBitsDef,
  parameter int MaxHexDigits = MaxHexDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slx_in_if.sink     in_i,
  slx_out_if.source  out_o
);

  rbuf_t res, head;
  logic  full, empty, pop, take;

  assign in_i.ready = !full;
  assign take       = in_i.valid && !full;

  slx_front #(
    .IntegerBits  (IntegerBits),
    .MaxHexDigits (MaxHexDigits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .char_byte_i    (in_i.char_byte),
    .end_of_input_i (in_i.end_of_input),
    .res_o          (res)
  );

  slx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take && res.cnt != 2'd0),
    .data_i  (res),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  slx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
